@@ hdl/hti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hti_pkg: shared types and constants for the heightmap interpolator
// Map geometry, bank addressing, operation codes and stage payload types.
// ----------------------------------------------------------------------------
package hti_pkg;

  localparam int CoordW   = 8;                  // tile row / column width
  localparam int FracW    = 8;                  // fraction width per axis
  localparam int PosW     = CoordW + FracW;     // 8.8 position
  localparam int IndexW   = 2 * CoordW;         // row*256 + column
  localparam int HeightW  = 8;                  // stored height byte
  localparam int WeightW  = FracW + 1;          // weights run up to 256
  localparam int ProdW    = HeightW + WeightW;  // corner times weight
  localparam int SumW     = ProdW + 1;          // three products added
  localparam int ResultW  = 13;                 // sum >> 3 fits 0..8160
  localparam int BlendShift = 3;
  localparam int NumBanks = 4;                  // row parity x column parity
  localparam int BankSelW = $clog2(NumBanks);
  localparam int BankAddrW = IndexW - BankSelW; // 14 bits
  localparam int BankDepth = 1 << BankAddrW;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Triangle within a tile: diagonal chosen by parity, side by the fractions.
  typedef enum logic [1:0] {
    TRI_ODD_LOW,    // odd parity, fx + fy < 256
    TRI_ODD_HIGH,   // odd parity, fx + fy >= 256
    TRI_EVEN_LOW,   // even parity, fx <= fy
    TRI_EVEN_HIGH   // even parity, fx > fy
  } tri_t;

  typedef struct packed {
    logic [FracW-1:0] fx;
    logic [FracW-1:0] fy;
    logic             odd;
  } query_t;

  typedef struct packed {
    logic [HeightW-1:0] c00;
    logic [HeightW-1:0] c10;
    logic [HeightW-1:0] c01;
    logic [HeightW-1:0] c11;
  } corners_t;

endpackage

@@ hdl/hti_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hti_bank: one bank of the height map
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module hti_bank (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [hti_pkg::BankAddrW-1:0] wr_addr,
  input  logic [hti_pkg::HeightW-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [hti_pkg::BankAddrW-1:0] rd_addr,
  output logic [hti_pkg::HeightW-1:0]   rd_data
);
  import hti_pkg::*;

  logic [HeightW-1:0] mem [BankDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/hti_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hti_store: height map split into four parity banks
// Maps cell writes to their bank and fetches the four corners of a tile
// in a single read, one from each bank.
// ----------------------------------------------------------------------------
module hti_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [hti_pkg::IndexW-1:0]  wr_index,
  input  logic [hti_pkg::HeightW-1:0] wr_height,
  input  logic                        rd_en,
  input  logic [hti_pkg::CoordW-1:0]  rd_row,
  input  logic [hti_pkg::CoordW-1:0]  rd_col,
  output hti_pkg::corners_t           corners
);
  import hti_pkg::*;

  logic [HeightW-1:0] bank_q [NumBanks];
  logic               row0;
  logic               col0;
  logic [CoordW-1:0]  row_inc;
  logic [CoordW-1:0]  col_inc;
  logic [CoordW-1:0]  wr_row;
  logic [CoordW-1:0]  wr_col;

  assign row_inc = rd_row + CoordW'(1);
  assign col_inc = rd_col + CoordW'(1);
  assign wr_row  = wr_index[IndexW-1:CoordW];
  assign wr_col  = wr_index[CoordW-1:0];

  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    localparam logic [BankSelW-1:0] Sel = BankSelW'(b);
    logic [CoordW-1:0]    row_sel;
    logic [CoordW-1:0]    col_sel;
    logic                 bank_wr;

    // Of row and row+1 exactly one has this bank's parity; same for columns.
    assign row_sel = (rd_row[0] == Sel[1]) ? rd_row : row_inc;
    assign col_sel = (rd_col[0] == Sel[0]) ? rd_col : col_inc;
    assign bank_wr = wr_en && (wr_row[0] == Sel[1]) && (wr_col[0] == Sel[0]);

    hti_bank u_bank (
      .clk     (clk),
      .wr_en   (bank_wr),
      .wr_addr ({wr_row[CoordW-1:1], wr_col[CoordW-1:1]}),
      .wr_data (wr_height),
      .rd_en   (rd_en),
      .rd_addr ({row_sel[CoordW-1:1], col_sel[CoordW-1:1]}),
      .rd_data (bank_q[b])
    );
  end

  // Hold the tile parities alongside the read data to undo the banking.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      row0 <= rd_row[0];
      col0 <= rd_col[0];
    end
  end

  assign corners.c00 = bank_q[{row0,  col0}];
  assign corners.c10 = bank_q[{row0,  ~col0}];
  assign corners.c01 = bank_q[{~row0, col0}];
  assign corners.c11 = bank_q[{~row0, ~col0}];

endmodule

@@ hdl/hti_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hti_blend: barycentric blend of three tile corners
// Picks the triangle and weights, registers three products, then adds
// and scales them into the output register.
// ----------------------------------------------------------------------------
module hti_blend (
  input  logic                        clk,
  input  logic                        load_prod,
  input  logic                        load_out,
  input  hti_pkg::query_t             query,
  input  hti_pkg::corners_t           corners,
  output logic [hti_pkg::ResultW-1:0] height_out
);
  import hti_pkg::*;

  localparam logic [WeightW-1:0] Full = WeightW'(1 << FracW);      // 256
  localparam logic [WeightW-1:0] Top  = WeightW'((1 << FracW) - 1); // 255

  tri_t               tri_sel;
  logic [WeightW-1:0] fx9;
  logic [WeightW-1:0] fy9;
  logic [WeightW-1:0] fsum;
  logic [HeightW-1:0] p0, p1, p2;
  logic [WeightW-1:0] w0, w1, w2;
  logic [ProdW-1:0]   prod0, prod1, prod2;
  logic [SumW-1:0]    total;

  assign fx9  = {1'b0, query.fx};
  assign fy9  = {1'b0, query.fy};
  assign fsum = fx9 + fy9;

  always_comb begin
    if (query.odd) begin
      tri_sel = fsum[FracW] ? TRI_ODD_HIGH : TRI_ODD_LOW;
    end else begin
      tri_sel = (query.fx <= query.fy) ? TRI_EVEN_LOW : TRI_EVEN_HIGH;
    end
  end

  always_comb begin
    unique case (tri_sel)
      TRI_ODD_LOW: begin
        p0 = corners.c00; w0 = Full - fsum;
        p1 = corners.c10; w1 = fx9;
        p2 = corners.c01; w2 = fy9;
      end
      TRI_ODD_HIGH: begin
        // upper triangle weights c10 by 255 - fy
        p0 = corners.c01; w0 = Full - fx9;
        p1 = corners.c11; w1 = fsum - Top;
        p2 = corners.c10; w2 = Top - fy9;
      end
      TRI_EVEN_LOW: begin
        p0 = corners.c00; w0 = Full - fy9;
        p1 = corners.c01; w1 = fy9 - fx9;
        p2 = corners.c11; w2 = fx9;
      end
      TRI_EVEN_HIGH: begin
        p0 = corners.c00; w0 = Full - fx9;
        p1 = corners.c10; w1 = fx9 - fy9;
        p2 = corners.c11; w2 = fy9;
      end
      default: begin
        p0 = corners.c00; w0 = Full;
        p1 = corners.c10; w1 = '0;
        p2 = corners.c01; w2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod0 <= ProdW'(p0) * ProdW'(w0);
      prod1 <= ProdW'(p1) * ProdW'(w1);
      prod2 <= ProdW'(p2) * ProdW'(w2);
    end
  end

  // Weights total 256, so the sum stays below 2^16 and the shift fits 13 bits.
  assign total = SumW'(prod0) + SumW'(prod1) + SumW'(prod2);

  always_ff @(posedge clk) begin
    if (load_out) begin
      height_out <= total[BlendShift +: ResultW];
    end
  end

endmodule

@@ hdl/heightmap_triangle_interp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_triangle_interp: triangulated interpolation over a height map
// 256 x 256 byte map loaded by write transactions, sampled by queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one transaction per cycle while in_ready is high.
//   operation = write stores cell_height at cell_index and gives no result;
//   operation = query samples the map at pos_x / pos_y (8.8 fixed point)
//   and gives one height_out transaction on the output channel.
//   A query passes through the bank read registers, the weighted product
//   registers and the sum-and-scale output register, in that order, and
//   its result is offered on the output channel from the output register.
//   Throughput: one transaction per cycle while in_ready is high, writes and queries mixed freely.
//   The map sits in four banks by row and column parity, so the three
//   corners of a triangle come from distinct banks in a single read.
//   Writes and reads both act at the accepting edge, in order, so a query
//   right behind a write already sees the new byte.
//   Reset clears the pipeline valid flags only; map cells read back
//   undefined until written, and there is no clearing pass.
//   When the receiver stalls, the pipeline fills and in_ready drops once all
//   three stages hold a result; results are never lost or repeated.
// ----------------------------------------------------------------------------
module heightmap_triangle_interp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [0:0]                  operation,
  input  logic [hti_pkg::IndexW-1:0]  cell_index,
  input  logic [hti_pkg::HeightW-1:0] cell_height,
  input  logic [hti_pkg::PosW-1:0]    pos_x,
  input  logic [hti_pkg::PosW-1:0]    pos_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hti_pkg::ResultW-1:0] height_out
);
  import hti_pkg::*;

  logic     in_take;
  logic     do_write;
  logic     do_query;
  logic     v1;        // corners being read / held in bank output registers
  logic     v2;        // products registered
  logic     free_out;
  logic     free2;
  logic     free1;
  logic     move1;
  logic     move2;
  query_t   query;
  query_t   query_in;
  corners_t corners;

  // Stall chain: a stage may load when it is empty or its holder moves on.
  assign free_out = !out_valid || out_ready;
  assign move2    = v2 && free_out;
  assign free2    = !v2 || free_out;
  assign move1    = v1 && free2;
  assign free1    = !v1 || free2;
  assign in_ready = free1;

  assign in_take  = in_valid && in_ready;
  assign do_write = in_take && (op_t'(operation) == OP_WRITE);
  assign do_query = in_take && (op_t'(operation) == OP_QUERY);

  assign query_in.fx  = pos_x[FracW-1:0];
  assign query_in.fy  = pos_y[FracW-1:0];
  assign query_in.odd = pos_x[FracW] ^ pos_y[FracW];

  // Valid flags: set on load, clear when the stage drains with nothing behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_query) begin
        v1 <= 1'b1;
      end else if (move1) begin
        v1 <= 1'b0;
      end
      if (move1) begin
        v2 <= 1'b1;
      end else if (move2) begin
        v2 <= 1'b0;
      end
      if (move2) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the fractions and parity beside the bank read data.
  always_ff @(posedge clk) begin
    if (do_query) begin
      query <= query_in;
    end
  end

  hti_store u_store (
    .clk       (clk),
    .wr_en     (do_write),
    .wr_index  (cell_index),
    .wr_height (cell_height),
    .rd_en     (do_query),
    .rd_row    (pos_y[PosW-1:FracW]),
    .rd_col    (pos_x[PosW-1:FracW]),
    .corners   (corners)
  );

  hti_blend u_blend (
    .clk        (clk),
    .load_prod  (move1),
    .load_out   (move2),
    .query      (query),
    .corners    (corners),
    .height_out (height_out)
  );

endmodule

@@ bench/hti_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hti_tb_pkg: result tracking for the heightmap interpolator bench
// Mirrors the height map and keeps the heights that queries should return.
// ----------------------------------------------------------------------------
package hti_tb_pkg;
  import hti_pkg::*;

  class height_checker;
    logic [HeightW-1:0] map_copy [0:(1<<IndexW)-1];
    logic [ResultW-1:0] pending_heights [$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    // Pick the triangle, weight its three corners and scale back by 8.
    function logic [ResultW-1:0] blend_height(logic [PosW-1:0] px, logic [PosW-1:0] py);
      logic [CoordW-1:0] col, row, col_n, row_n;
      int unsigned       fx, fy, c00, c10, c01, c11, sum;
      tri_t              side;
      col   = px[PosW-1:FracW];
      row   = py[PosW-1:FracW];
      col_n = col + CoordW'(1);
      row_n = row + CoordW'(1);
      fx    = 32'(px[FracW-1:0]);
      fy    = 32'(py[FracW-1:0]);
      c00   = 32'(map_copy[{row, col}]);
      c10   = 32'(map_copy[{row, col_n}]);
      c01   = 32'(map_copy[{row_n, col}]);
      c11   = 32'(map_copy[{row_n, col_n}]);
      if (col[0] ^ row[0]) begin
        side = (fx + fy >= 256) ? TRI_ODD_HIGH : TRI_ODD_LOW;
      end else begin
        side = (fx <= fy) ? TRI_EVEN_LOW : TRI_EVEN_HIGH;
      end
      case (side)
        TRI_ODD_LOW: begin
          sum = c00 * (256 - fx - fy) + c10 * fx + c01 * fy;
        end
        TRI_ODD_HIGH: begin
          sum = c01 * (256 - fx) + c11 * (fx + fy - 255) + c10 * (255 - fy);
        end
        TRI_EVEN_LOW: begin
          sum = c00 * (256 - fy) + c01 * (fy - fx) + c11 * fx;
        end
        default: begin
          sum = c00 * (256 - fx) + c10 * (fx - fy) + c11 * fy;
        end
      endcase
      return ResultW'(sum >> BlendShift);
    endfunction

    function void note_input(op_t op, logic [IndexW-1:0] idx, logic [HeightW-1:0] h,
                             logic [PosW-1:0] px, logic [PosW-1:0] py);
      if (op == OP_WRITE) begin
        map_copy[idx] = h;
      end else begin
        pending_heights.push_back(blend_height(px, py));
      end
    endfunction

    function void check_result(logic [ResultW-1:0] actual);
      logic [ResultW-1:0] want;
      if (pending_heights.size() == 0) begin
        mismatches++;
        $display("%0t: height_out with no query outstanding: expected none, actual %0d",
                 $time, actual);
        return;
      end
      want = pending_heights.pop_front();
      checked++;
      if (actual !== want) begin
        mismatches++;
        $display("%0t: height_out mismatch: expected %0d, actual %0d", $time, want, actual);
      end
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for heightmap_triangle_interp
// Loads tiles of the map, queries every triangle of both diagonals with edge
// and wrap-around positions, then runs random tile loads, cell writes and queries under
// random idling on both channels, checking every height against a tracker.
// ----------------------------------------------------------------------------
module tb_top;
  import hti_pkg::*;
  import hti_tb_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int RandomItems = 400;
  localparam int DrainSpan   = 130;   // transactions between forced drains

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [0:0]           operation   = OP_WRITE;
  logic [IndexW-1:0]    cell_index  = '0;
  logic [HeightW-1:0]   cell_height = '0;
  logic [PosW-1:0]      pos_x       = '0;
  logic [PosW-1:0]      pos_y       = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [ResultW-1:0]   height_out;

  height_checker     tracker;
  bit                cell_written [0:(1<<IndexW)-1];
  logic [IndexW-1:0] ready_tiles [$];   // tiles with all four corners loaded
  bit                quiet = 1'b0;      // no idling on either side while set
  int unsigned       cycle_count = 0;
  int unsigned       items_sent = 0;
  int unsigned       writes_sent = 0;
  int unsigned       queries_sent = 0;

  heightmap_triangle_interp DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .cell_index  (cell_index),
    .cell_height (cell_height),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .height_out  (height_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold a watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d heights outstanding",
               cycle_count, tracker.pending_heights.size());
      $display("heightmap_triangle_interp regression: fail");
      $finish;
    end
  end

  // Sample both channels at the rising edge. Check the result first: a height
  // taken at this edge always belongs to a query taken at an earlier edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        tracker.check_result(height_out);
      end
      if (in_valid && in_ready) begin
        tracker.note_input(op_t'(operation), cell_index, cell_height, pos_x, pos_y);
      end
    end
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [HeightW-1:0] pick_height();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return HeightW'($urandom_range(0, 255));
  endfunction

  // Bias the fractions towards the triangle edges and the tile corners.
  function automatic logic [FracW-1:0] pick_fraction();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      3: return 8'd127;
      default: return FracW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CoordW-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CoordW'($urandom_range(0, 255));
  endfunction

  // Receiver: drop out_ready for random stretches once reset is released.
  initial begin
    int stall;
    stall = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  // Present one transaction at a falling edge and hold it until accepted.
  task automatic send_item(input op_t op, input logic [IndexW-1:0] idx,
                           input logic [HeightW-1:0] h,
                           input logic [PosW-1:0] px, input logic [PosW-1:0] py);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    = 1'b1;
    operation   = op;
    cell_index  = idx;
    cell_height = h;
    pos_x       = px;
    pos_y       = py;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == OP_WRITE) writes_sent++;
    else queries_sent++;
  endtask

  // Write one cell; the query fields carry noise that the block must ignore.
  task automatic write_cell(input logic [CoordW-1:0] row, input logic [CoordW-1:0] col,
                            input logic [HeightW-1:0] h);
    cell_written[{row, col}] = 1'b1;
    send_item(OP_WRITE, {row, col}, h, PosW'($urandom_range(0, 65535)),
              PosW'($urandom_range(0, 65535)));
  endtask

  // Query inside a tile; the write fields carry noise.
  task automatic query_at(input logic [CoordW-1:0] row, input logic [CoordW-1:0] col,
                          input logic [FracW-1:0] fx, input logic [FracW-1:0] fy);
    send_item(OP_QUERY, IndexW'($urandom_range(0, 65535)), HeightW'($urandom_range(0, 255)),
              {col, fx}, {row, fy});
  endtask

  // Load the four corners of a tile (wrapping at the map edge), leaving some
  // already loaded corners as they are, and mark the tile as safe to query.
  task automatic lay_tile(input logic [CoordW-1:0] row, input logic [CoordW-1:0] col);
    logic [CoordW-1:0] r_c, c_c;
    for (int k = 0; k < 4; k++) begin
      r_c = row + CoordW'(k / 2);
      c_c = col + CoordW'(k % 2);
      if (!cell_written[{r_c, c_c}] || $urandom_range(0, 1) == 1) begin
        write_cell(r_c, c_c, pick_height());
      end
    end
    ready_tiles.push_back({row, col});
  endtask

  task automatic query_ready_tile();
    logic [IndexW-1:0] t;
    t = ready_tiles[$urandom_range(0, ready_tiles.size() - 1)];
    query_at(CoordW'(t >> CoordW), CoordW'(t), pick_fraction(), pick_fraction());
  endtask

  // Hold the sender off until every outstanding height has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending_heights.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned target, next_drain, pick, burst;
    tracker = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: tile (0,0) has even parity, tile (0,1) odd parity.
    write_cell(8'd0, 8'd0, 8'd255);
    write_cell(8'd0, 8'd1, 8'd0);
    write_cell(8'd1, 8'd0, 8'd128);
    write_cell(8'd1, 8'd1, 8'd255);
    write_cell(8'd0, 8'd2, 8'd255);
    write_cell(8'd1, 8'd2, 8'd0);
    // Wrap-around tiles at the far corner and the far column; all corners of
    // tile (255,255) are full height, so its origin gives the top result.
    write_cell(8'd255, 8'd255, 8'd255);
    write_cell(8'd255, 8'd0, 8'd255);
    write_cell(8'd0, 8'd255, 8'd255);
    write_cell(8'd1, 8'd255, 8'd0);
    ready_tiles.push_back({8'd0, 8'd0});
    ready_tiles.push_back({8'd0, 8'd1});
    ready_tiles.push_back({8'd255, 8'd255});
    ready_tiles.push_back({8'd0, 8'd255});

    // Even diagonal: both triangles, the diagonal itself and the corners.
    query_at(8'd0, 8'd0, 8'd0, 8'd0);
    query_at(8'd0, 8'd0, 8'd255, 8'd255);
    query_at(8'd0, 8'd0, 8'd255, 8'd0);
    query_at(8'd0, 8'd0, 8'd0, 8'd255);
    query_at(8'd0, 8'd0, 8'd128, 8'd128);
    // Odd diagonal: lower side, the upper side with its 255-fy weight, and
    // both sides of fx + fy = 256.
    query_at(8'd0, 8'd1, 8'd0, 8'd0);
    query_at(8'd0, 8'd1, 8'd255, 8'd255);
    query_at(8'd0, 8'd1, 8'd128, 8'd128);
    query_at(8'd0, 8'd1, 8'd127, 8'd128);
    query_at(8'd0, 8'd1, 8'd255, 8'd0);
    query_at(8'd255, 8'd255, 8'd0, 8'd0);
    query_at(8'd0, 8'd255, 8'd200, 8'd100);

    // Drain fully before the random traffic starts.
    wait_for_results();

    // Random: mostly load a tile and sample it, else sample an older tile or
    // overwrite an arbitrary cell. Every fifth stretch runs with no idling.
    target     = items_sent + RandomItems;
    next_drain = items_sent + DrainSpan;
    while (items_sent < target) begin
      quiet = (((items_sent / 40) % 5) == 2);
      pick  = $urandom_range(0, 99);
      if (pick < 45) begin
        lay_tile(pick_coord(), pick_coord());
        burst = $urandom_range(1, 3);
        repeat (burst) query_at(CoordW'(ready_tiles[$] >> CoordW), CoordW'(ready_tiles[$]),
                                pick_fraction(), pick_fraction());
      end else if (pick < 85) begin
        query_ready_tile();
      end else begin
        write_cell(CoordW'($urandom_range(0, 255)), CoordW'($urandom_range(0, 255)),
                   HeightW'($urandom_range(0, 255)));
      end
      if (items_sent >= next_drain) begin
        wait_for_results();
        next_drain = items_sent + DrainSpan;
      end
    end
    quiet = 1'b0;

    // Wait for the tail, then a few more edges to catch any stray result.
    wait_for_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d cell writes and %0d queries over %0d loaded tiles,",
             writes_sent, queries_sent, ready_tiles.size());
    $display("with both diagonals, wrap-around tiles and random stalls; %0d heights checked.",
             tracker.checked);
    if (tracker.mismatches == 0) begin
      $display("heightmap_triangle_interp regression: pass");
    end else begin
      $display("heightmap_triangle_interp regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/hti_pkg.sv
hdl/hti_bank.sv
hdl/hti_store.sv
hdl/hti_blend.sv
hdl/heightmap_triangle_interp.sv
bench/hti_tb_pkg.sv
bench/tb_top.sv
